// ===== rtl/sccb_pkg.sv =====
package sccb_pkg;

    // command codes on the input channel
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_DEV_ADDR    = 2'd0;
    localparam logic [1:0] CFG_HALF_PERIOD = 2'd1;
    localparam logic [1:0] CFG_WR_ATTEMPTS = 2'd2;
    localparam logic [1:0] CFG_RD_ATTEMPTS = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // reset values of the configuration registers
    localparam logic [7:0]  RST_DEV_ADDR    = 8'd66;
    localparam logic [15:0] RST_HALF_PERIOD = 16'd100;
    localparam logic [7:0]  RST_WR_ATTEMPTS = 8'd20;
    localparam logic [7:0]  RST_RD_ATTEMPTS = 8'd30;

    typedef enum logic [15:0] {
        PH_IDLE  = 16'h0001,
        PH_ST_A  = 16'h0002,
        PH_ST_B  = 16'h0004,
        PH_TX_LO = 16'h0008,
        PH_TX_HI = 16'h0010,
        PH_AK_LO = 16'h0020,
        PH_AK_HI = 16'h0040,
        PH_SP_A  = 16'h0080,
        PH_SP_B  = 16'h0100,
        PH_SP_C  = 16'h0200,
        PH_RX_LO = 16'h0400,
        PH_RX_HI = 16'h0800,
        PH_MA_A  = 16'h1000,
        PH_MA_B  = 16'h2000,
        PH_MA_C  = 16'h4000,
        PH_MA_D  = 16'h8000
    } t_phase;

    typedef enum logic [7:0] {
        SG_DEV    = 8'h01,
        SG_REG    = 8'h02,
        SG_DATA   = 8'h04,
        SG_STOP1  = 8'h08,
        SG_DEV_RD = 8'h10,
        SG_RX     = 8'h20,
        SG_FINAL  = 8'h40,
        SG_NACK   = 8'h80
    } t_segment;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } t_op_kind;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] read_count;
        logic       sda_sample;
    } t_in;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_enable;
        logic       busy_res;
        logic       done_res;
        logic       success;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic       byte_last;
    } t_out;

    // classified request held in the queue
    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] read_count;
        logic       sda_sample;
    } t_op;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

// ===== rtl/sccb_queue.sv =====
module sccb_queue #(
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  sccb_pkg::t_op i_push_data,
    output logic         o_full,
    input  logic         i_pop,
    output sccb_pkg::t_op o_pop_data,
    output logic         o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sccb_pkg::t_op    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/sccb_engine.sv =====
module sccb_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sccb_pkg::t_cfg_wr i_cfg,
    input  logic              i_op_empty,
    input  sccb_pkg::t_op     i_op,
    output logic              o_op_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sccb_pkg::t_out    o_out
);

    // configuration
    logic [7:0]  r_dev_addr;
    logic [15:0] r_half_period;
    logic [7:0]  r_wr_attempts;
    logic [7:0]  r_rd_attempts;

    // bus state
    sccb_pkg::t_phase   r_phase,  n_phase;
    sccb_pkg::t_segment r_segment, n_segment;
    logic        r_is_read,   n_is_read;
    logic [7:0]  r_latch_reg, n_latch_reg;
    logic [7:0]  r_latch_dat, n_latch_dat;
    logic [7:0]  r_shift,     n_shift;
    logic [3:0]  r_bit_cnt,   n_bit_cnt;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [7:0]  r_attempt,   n_attempt;
    logic [15:0] r_delay,     n_delay;
    logic [7:0]  r_req_cnt,   n_req_cnt;

    logic           r_out_valid;
    sccb_pkg::t_out r_out;
    sccb_pkg::t_out n_res;

    logic        fire;
    logic        end_iv;
    logic        ackbit;
    logic        fail_now;
    logic        done_now;
    logic        ok_now;
    logic [7:0]  attempt_inc;
    logic [7:0]  limit;
    logic        give_up;
    logic [3:0]  bit_inc;
    logic [7:0]  shift_rx;
    logic [7:0]  bytes_dec;

    assign fire        = !i_op_empty && (!r_out_valid || i_out_ready);
    assign o_op_pop    = fire;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign end_iv      = ({1'b0, r_delay} + 17'd1) >= {1'b0, r_half_period};
    assign ackbit      = (r_bytes_left == 8'd1);
    assign attempt_inc = r_attempt + 8'd1;
    assign limit       = r_is_read ? r_rd_attempts : r_wr_attempts;
    assign give_up     = (attempt_inc >= limit) || (attempt_inc == 8'd0);
    assign bit_inc     = r_bit_cnt + 4'd1;
    assign shift_rx    = {r_shift[6:0], i_op.sda_sample};
    assign bytes_dec   = r_bytes_left - 8'd1;

    always_comb begin
        n_phase      = r_phase;
        n_segment    = r_segment;
        n_is_read    = r_is_read;
        n_latch_reg  = r_latch_reg;
        n_latch_dat  = r_latch_dat;
        n_shift      = r_shift;
        n_bit_cnt    = r_bit_cnt;
        n_bytes_left = r_bytes_left;
        n_attempt    = r_attempt;
        n_delay      = r_delay;
        n_req_cnt    = r_req_cnt;
        fail_now     = 1'b0;
        done_now     = 1'b0;
        ok_now       = 1'b0;

        n_res            = '0;
        n_res.scl_level  = 1'b1;
        n_res.sda_level  = 1'b1;
        n_res.sda_enable = 1'b1;
        n_res.busy_res   = (r_phase != sccb_pkg::PH_IDLE);

        // line levels of this tick
        unique case (r_phase)
            sccb_pkg::PH_ST_A: begin
                n_res.sda_enable = 1'b0;
            end
            sccb_pkg::PH_ST_B: begin
                n_res.sda_level = 1'b0;
            end
            sccb_pkg::PH_TX_LO: begin
                n_res.scl_level = 1'b0;
                n_res.sda_level = r_shift[7];
            end
            sccb_pkg::PH_TX_HI: begin
                n_res.sda_level = r_shift[7];
            end
            sccb_pkg::PH_AK_LO, sccb_pkg::PH_RX_LO, sccb_pkg::PH_MA_A: begin
                n_res.scl_level  = 1'b0;
                n_res.sda_enable = 1'b0;
            end
            sccb_pkg::PH_AK_HI, sccb_pkg::PH_RX_HI: begin
                n_res.sda_enable = 1'b0;
            end
            sccb_pkg::PH_SP_A: begin
                n_res.scl_level = 1'b0;
                n_res.sda_level = 1'b0;
            end
            sccb_pkg::PH_SP_B: begin
                n_res.sda_level = 1'b0;
            end
            sccb_pkg::PH_MA_B, sccb_pkg::PH_MA_D: begin
                n_res.scl_level = 1'b0;
                n_res.sda_level = ackbit;
            end
            sccb_pkg::PH_MA_C: begin
                n_res.sda_level = ackbit;
            end
            default: begin
            end
        endcase

        if (r_phase == sccb_pkg::PH_IDLE) begin
            if (i_op.kind == sccb_pkg::OP_WRITE || i_op.kind == sccb_pkg::OP_READ) begin
                n_is_read    = (i_op.kind == sccb_pkg::OP_READ);
                n_latch_reg  = i_op.reg_addr;
                n_latch_dat  = i_op.write_data;
                n_req_cnt    = i_op.read_count;
                n_bytes_left = i_op.read_count;
                n_attempt    = 8'd0;
                n_segment    = sccb_pkg::SG_DEV;
                n_phase      = sccb_pkg::PH_ST_A;
                n_delay      = 16'd0;
            end
        end else if (!end_iv) begin
            n_delay = r_delay + 16'd1;
        end else begin
            n_delay = 16'd0;
            unique case (r_phase)
                sccb_pkg::PH_ST_A: begin
                    if (!i_op.sda_sample) begin
                        fail_now = 1'b1;
                    end else begin
                        n_phase = sccb_pkg::PH_ST_B;
                    end
                end
                sccb_pkg::PH_ST_B: begin
                    if (i_op.sda_sample) begin
                        fail_now = 1'b1;
                    end else begin
                        n_shift   = (r_segment == sccb_pkg::SG_DEV_RD) ?
                                    r_dev_addr + 8'd1 : r_dev_addr;
                        n_bit_cnt = 4'd0;
                        n_phase   = sccb_pkg::PH_TX_LO;
                    end
                end
                sccb_pkg::PH_TX_LO: n_phase = sccb_pkg::PH_TX_HI;
                sccb_pkg::PH_TX_HI: begin
                    n_shift   = {r_shift[6:0], 1'b0};
                    n_bit_cnt = bit_inc;
                    n_phase   = (bit_inc >= 4'd8) ? sccb_pkg::PH_AK_LO : sccb_pkg::PH_TX_LO;
                end
                sccb_pkg::PH_AK_LO: n_phase = sccb_pkg::PH_AK_HI;
                sccb_pkg::PH_AK_HI: begin
                    if (r_segment == sccb_pkg::SG_DEV) begin
                        if (i_op.sda_sample) begin
                            n_segment = sccb_pkg::SG_NACK;
                            n_phase   = sccb_pkg::PH_SP_A;
                        end else begin
                            n_segment = sccb_pkg::SG_REG;
                            n_shift   = r_latch_reg;
                            n_bit_cnt = 4'd0;
                            n_phase   = sccb_pkg::PH_TX_LO;
                        end
                    end else if (r_segment == sccb_pkg::SG_REG) begin
                        if (r_is_read) begin
                            n_segment = sccb_pkg::SG_STOP1;
                            n_phase   = sccb_pkg::PH_SP_A;
                        end else begin
                            n_segment = sccb_pkg::SG_DATA;
                            n_shift   = r_latch_dat;
                            n_bit_cnt = 4'd0;
                            n_phase   = sccb_pkg::PH_TX_LO;
                        end
                    end else if (r_segment == sccb_pkg::SG_DEV_RD) begin
                        if (i_op.sda_sample) begin
                            n_segment = sccb_pkg::SG_NACK;
                            n_phase   = sccb_pkg::PH_SP_A;
                        end else if (r_req_cnt == 8'd0) begin
                            n_segment = sccb_pkg::SG_FINAL;
                            n_phase   = sccb_pkg::PH_SP_A;
                        end else begin
                            n_segment    = sccb_pkg::SG_RX;
                            n_bytes_left = r_req_cnt;
                            n_bit_cnt    = 4'd0;
                            n_shift      = 8'd0;
                            n_phase      = sccb_pkg::PH_RX_LO;
                        end
                    end else begin
                        n_segment = sccb_pkg::SG_FINAL;
                        n_phase   = sccb_pkg::PH_SP_A;
                    end
                end
                sccb_pkg::PH_SP_A: n_phase = sccb_pkg::PH_SP_B;
                sccb_pkg::PH_SP_B: n_phase = sccb_pkg::PH_SP_C;
                sccb_pkg::PH_SP_C: begin
                    if (r_segment == sccb_pkg::SG_STOP1) begin
                        n_segment = sccb_pkg::SG_DEV_RD;
                        n_phase   = sccb_pkg::PH_ST_A;
                    end else if (r_segment == sccb_pkg::SG_NACK) begin
                        fail_now = 1'b1;
                    end else begin
                        done_now = 1'b1;
                        ok_now   = 1'b1;
                        n_phase  = sccb_pkg::PH_IDLE;
                    end
                end
                sccb_pkg::PH_RX_LO: n_phase = sccb_pkg::PH_RX_HI;
                sccb_pkg::PH_RX_HI: begin
                    n_shift   = shift_rx;
                    n_bit_cnt = bit_inc;
                    if (bit_inc >= 4'd8) begin
                        n_res.byte_valid = 1'b1;
                        n_res.byte_value = shift_rx;
                        n_res.byte_last  = ackbit;
                        n_phase          = sccb_pkg::PH_MA_A;
                    end else begin
                        n_phase = sccb_pkg::PH_RX_LO;
                    end
                end
                sccb_pkg::PH_MA_A: n_phase = sccb_pkg::PH_MA_B;
                sccb_pkg::PH_MA_B: n_phase = sccb_pkg::PH_MA_C;
                sccb_pkg::PH_MA_C: n_phase = sccb_pkg::PH_MA_D;
                sccb_pkg::PH_MA_D: begin
                    n_bytes_left = bytes_dec;
                    if (bytes_dec == 8'd0) begin
                        n_segment = sccb_pkg::SG_FINAL;
                        n_phase   = sccb_pkg::PH_SP_A;
                    end else begin
                        n_bit_cnt = 4'd0;
                        n_shift   = 8'd0;
                        n_phase   = sccb_pkg::PH_RX_LO;
                    end
                end
                default: n_phase = sccb_pkg::PH_IDLE;
            endcase

            // failed attempt: retry from start, or give up
            if (fail_now) begin
                n_attempt = attempt_inc;
                if (give_up) begin
                    done_now = 1'b1;
                    ok_now   = 1'b0;
                    n_phase  = sccb_pkg::PH_IDLE;
                end else begin
                    n_segment = sccb_pkg::SG_DEV;
                    n_phase   = sccb_pkg::PH_ST_A;
                end
            end
        end

        n_res.done_res = done_now;
        n_res.success  = done_now && ok_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr    <= sccb_pkg::RST_DEV_ADDR;
            r_half_period <= sccb_pkg::RST_HALF_PERIOD;
            r_wr_attempts <= sccb_pkg::RST_WR_ATTEMPTS;
            r_rd_attempts <= sccb_pkg::RST_RD_ATTEMPTS;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                sccb_pkg::CFG_DEV_ADDR:    r_dev_addr    <= i_cfg.data[7:0];
                sccb_pkg::CFG_HALF_PERIOD: r_half_period <= i_cfg.data;
                sccb_pkg::CFG_WR_ATTEMPTS: r_wr_attempts <= i_cfg.data[7:0];
                sccb_pkg::CFG_RD_ATTEMPTS: r_rd_attempts <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= sccb_pkg::PH_IDLE;
            r_segment    <= sccb_pkg::SG_DEV;
            r_is_read    <= 1'b0;
            r_latch_reg  <= 8'd0;
            r_latch_dat  <= 8'd0;
            r_shift      <= 8'd0;
            r_bit_cnt    <= 4'd0;
            r_bytes_left <= 8'd0;
            r_attempt    <= 8'd0;
            r_delay      <= 16'd0;
            r_req_cnt    <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (fire) begin
                r_phase      <= n_phase;
                r_segment    <= n_segment;
                r_is_read    <= n_is_read;
                r_latch_reg  <= n_latch_reg;
                r_latch_dat  <= n_latch_dat;
                r_shift      <= n_shift;
                r_bit_cnt    <= n_bit_cnt;
                r_bytes_left <= n_bytes_left;
                r_attempt    <= n_attempt;
                r_delay      <= n_delay;
                r_req_cnt    <= n_req_cnt;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_res;
        end
    end

endmodule

// ===== rtl/sccb_register_master.sv =====
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready   i_in  (sccb_pkg::t_in)
// out       output     o_out_valid / i_out_ready o_out (sccb_pkg::t_out)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One request per cycle is taken and one result leaves per cycle while the output is not stalled.
// A request is registered in the request queue, then in the bus engine, whose single
// state update per tick feeds the output register.
// Reset (synchronous, active low) empties the queue and the output register,
// returns the bus to idle and reloads the configuration defaults.
// A stalled output holds the engine; the queue keeps taking requests until full.

module sccb_register_master #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sccb_pkg::t_in                       i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sccb_pkg::t_out                      o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sccb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sccb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    sccb_pkg::t_op     op_in;
    sccb_pkg::t_op     op_head;
    sccb_pkg::t_cfg_wr cfg_wr;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;

    // front: classify the command; unknown codes act as a plain tick
    always_comb begin
        op_in.reg_addr   = i_in.reg_addr;
        op_in.write_data = i_in.write_data;
        op_in.read_count = i_in.read_count;
        op_in.sda_sample = i_in.sda_sample;
        unique case (i_in.command)
            sccb_pkg::CMD_WRITE: op_in.kind = sccb_pkg::OP_WRITE;
            sccb_pkg::CMD_READ:  op_in.kind = sccb_pkg::OP_READ;
            default:             op_in.kind = sccb_pkg::OP_TICK;
        endcase
    end

    assign o_in_ready   = !q_full;
    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    sccb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_in_valid),
        .i_push_data (op_in),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (op_head),
        .o_empty     (q_empty)
    );

    // back: bus timing engine with output register
    sccb_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_wr),
        .i_op_empty  (q_empty),
        .i_op        (op_head),
        .o_op_pop    (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
